@@ rtl/core/bole_pkg.sv @@
`default_nettype none

package bole_pkg;

  // list geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned FIDX_W  = 4;
  localparam int unsigned TOTAL_W = 5;
  localparam int unsigned CAP_W   = 5;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_VALUE = 3'd5,
    OP_SEARCH    = 3'd6
  } op_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } status_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic cfg_write;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/bole_ctrl.sv @@
`default_nettype none

module bole_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire                out_stall,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  output bole_pkg::cmd_t     cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   in_stall_r;
  logic   out_valid_r;
  logic   accept;
  logic   fire;
  logic   drain;

  // handshake decode
  assign accept = in_valid && !in_stall_r;
  assign drain  = out_valid_r && !out_stall;
  assign fire   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r    <= S_EXEC;
            in_stall_r <= 1'b1;
          end else begin
            in_stall_r <= 1'b0;
          end
          if (drain) begin
            out_valid_r <= 1'b0;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_r     <= S_IDLE;
            in_stall_r  <= 1'b0;
            out_valid_r <= 1'b1;
          end else if (drain) begin
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall      = in_stall_r;
  assign out_valid     = out_valid_r;
  assign cfg_ready     = 1'b1;
  assign cmd.capture   = accept;
  assign cmd.execute   = fire;
  assign cmd.cfg_write = cfg_valid;

endmodule

`default_nettype wire

@@ rtl/core/bole_dpath.sv @@
`default_nettype none

module bole_dpath (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  bole_pkg::cmd_t                      cmd,
  input  wire        [bole_pkg::OP_W-1:0]     in_op,
  input  wire signed [bole_pkg::VAL_W-1:0]    in_value,
  input  wire        [bole_pkg::POS_W-1:0]    in_position,
  input  wire        [bole_pkg::CAP_W-1:0]    cfg_data,
  output logic       [bole_pkg::STAT_W-1:0]   out_status,
  output logic signed [bole_pkg::VAL_W-1:0]   out_removed_value,
  output logic       [bole_pkg::FIDX_W-1:0]   out_found_index,
  output logic       [bole_pkg::TOTAL_W-1:0]  out_entry_total
);

  localparam int unsigned DEPTH = bole_pkg::DEPTH;
  localparam int unsigned IDX_W = bole_pkg::IDX_W;
  localparam int unsigned CNT_W = bole_pkg::CNT_W;
  localparam int unsigned VAL_W = bole_pkg::VAL_W;

  // captured item
  logic [bole_pkg::OP_W-1:0]  op_r;
  logic [VAL_W-1:0]           value_r;
  logic [bole_pkg::POS_W-1:0] position_r;

  // list cells and bookkeeping
  logic [VAL_W-1:0]           cells_r   [DEPTH];
  logic [VAL_W-1:0]           cells_nxt [DEPTH];
  logic [VAL_W-1:0]           prev_w    [DEPTH];
  logic [VAL_W-1:0]           next_w    [DEPTH];
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;
  logic [bole_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]           cap_eff;
  logic                       full;

  // result registers
  bole_pkg::status_e           status_r;
  bole_pkg::status_e           status_nxt;
  logic [VAL_W-1:0]            removed_r;
  logic [VAL_W-1:0]            removed_nxt;
  logic [bole_pkg::FIDX_W-1:0] found_r;
  logic [bole_pkg::FIDX_W-1:0] found_nxt;
  logic [bole_pkg::TOTAL_W-1:0] total_r;

  // parallel compare
  logic [DEPTH-1:0]           match;
  logic                       any_match;
  logic [IDX_W-1:0]           first_idx;

  // shift control
  logic                       ins_do;
  logic [CNT_W-1:0]           ins_idx;
  logic                       rem_do;
  logic [IDX_W-1:0]           take_idx;

  // neighbor taps for shifting cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_nb
    if (k == 0) begin : g_first
      assign prev_w[k] = '0;
    end else begin : g_prev
      assign prev_w[k] = cells_r[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_w[k] = '0;
    end else begin : g_next
      assign next_w[k] = cells_r[k+1];
    end
  end

  // effective capacity and full flag
  assign cap_eff = (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_r);
  assign full    = count_r >= cap_eff;

  // compare every live cell against the item value
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      match[k] = (cells_r[k] == value_r) && (CNT_W'(k) < count_r);
    end
  end

  // first match, lowest index wins
  always_comb begin
    first_idx = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (match[k]) begin
        first_idx = IDX_W'(k);
      end
    end
  end
  assign any_match = |match;

  // operation decode
  always_comb begin
    status_nxt  = bole_pkg::ST_OK;
    removed_nxt = '0;
    found_nxt   = '0;
    ins_do      = 1'b0;
    ins_idx     = '0;
    rem_do      = 1'b0;
    take_idx    = '0;
    unique case (op_r)
      bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_BACK, bole_pkg::OP_INS_AT: begin
        if (full) begin
          status_nxt = bole_pkg::ST_FULL;
        end else if (op_r == bole_pkg::OP_INS_FRONT) begin
          ins_do = 1'b1;
        end else if (op_r == bole_pkg::OP_INS_BACK) begin
          ins_do  = 1'b1;
          ins_idx = count_r;
        end else if (CNT_W'(position_r) > count_r) begin
          status_nxt = bole_pkg::ST_BADPOS;
        end else begin
          ins_do  = 1'b1;
          ins_idx = CNT_W'(position_r);
        end
      end
      bole_pkg::OP_REM_FRONT, bole_pkg::OP_REM_BACK: begin
        if (count_r == '0) begin
          status_nxt  = bole_pkg::ST_EMPTY;
          removed_nxt = '1;
        end else begin
          rem_do = 1'b1;
          if (op_r == bole_pkg::OP_REM_BACK) begin
            take_idx = IDX_W'(count_r - CNT_W'(1));
          end
          removed_nxt = cells_r[take_idx];
        end
      end
      bole_pkg::OP_REM_VALUE: begin
        if (count_r == '0) begin
          status_nxt = bole_pkg::ST_EMPTY;
        end else if (any_match) begin
          rem_do      = 1'b1;
          take_idx    = first_idx;
          removed_nxt = cells_r[first_idx];
        end else begin
          status_nxt = bole_pkg::ST_NOTFOUND;
        end
      end
      bole_pkg::OP_SEARCH: begin
        if (count_r == '0) begin
          status_nxt = bole_pkg::ST_EMPTY;
        end else if (any_match) begin
          found_nxt = bole_pkg::FIDX_W'(first_idx);
        end else begin
          status_nxt = bole_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        status_nxt = bole_pkg::ST_OK;
      end
    endcase
  end

  // cell shift for insert and removal
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      cells_nxt[k] = cells_r[k];
      if (ins_do) begin
        if (CNT_W'(k) > ins_idx) begin
          cells_nxt[k] = prev_w[k];
        end else if (CNT_W'(k) == ins_idx) begin
          cells_nxt[k] = value_r;
        end
      end else if (rem_do) begin
        if (IDX_W'(k) >= take_idx) begin
          cells_nxt[k] = next_w[k];
        end
      end
    end
  end

  // count update
  always_comb begin
    count_nxt = count_r;
    if (ins_do) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rem_do) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // control state: count and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= bole_pkg::CAP_RESET;
    end else begin
      if (cmd.execute) begin
        count_r <= count_nxt;
      end
      if (cmd.cfg_write) begin
        cap_r <= cfg_data;
      end
    end
  end

  // item capture, cells and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_op;
      value_r    <= in_value;
      position_r <= in_position;
    end
    if (cmd.execute) begin
      for (int k = 0; k < DEPTH; k++) begin
        cells_r[k] <= cells_nxt[k];
      end
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      found_r   <= found_nxt;
      total_r   <= bole_pkg::TOTAL_W'(count_nxt);
    end
  end

  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_found_index   = found_r;
  assign out_entry_total   = total_r;

endmodule

`default_nettype wire

@@ rtl/core/bounded_ordered_list_engine_core.sv @@
// sequencing: an accepted item is captured, then executed, which registers its result
// item flow: one item at a time, set by the capture-then-execute controller;
//   a result held by out_stall delays execution; cells shift in parallel
// reset: synchronous, active low; clears entry count and control, capacity returns to 16,
//   list cells keep their contents and are never read above the count
`default_nettype none

module bounded_ordered_list_engine_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire        [bole_pkg::OP_W-1:0]     in_op,
  input  wire signed [bole_pkg::VAL_W-1:0]    in_value,
  input  wire        [bole_pkg::POS_W-1:0]    in_position,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic       [bole_pkg::STAT_W-1:0]   out_status,
  output logic signed [bole_pkg::VAL_W-1:0]   out_removed_value,
  output logic       [bole_pkg::FIDX_W-1:0]   out_found_index,
  output logic       [bole_pkg::TOTAL_W-1:0]  out_entry_total,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire        [bole_pkg::CAP_W-1:0]    cfg_data
);

  bole_pkg::cmd_t cmd;

  // sequencing
  bole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // list cells, compare and result registers
  bole_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_op             (in_op),
    .in_value          (in_value),
    .in_position       (in_position),
    .cfg_data          (cfg_data),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_found_index   (out_found_index),
    .out_entry_total   (out_entry_total)
  );

`ifndef SYNTHESIS
  // count never exceeds list depth
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_total <= bole_pkg::TOTAL_W'(bole_pkg::DEPTH)))
    else $error("entry total above depth");

  // an executed item always presents a result next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid)
    else $error("executed item produced no result");

  // acceptance and execution never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.execute))
    else $error("capture during execute");

  // a captured item is executed before another is taken
  a_capture_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> in_stall)
    else $error("input not stalled after capture");
`endif

endmodule

`default_nettype wire
